FILE: rtl/rhs_pkg.sv
// Shared types and constants for the roast heat sequencer.
// Holds register indexes, reset values and the state/config/result structs.
// No dependencies.
package rhs_pkg;

    localparam int TEMP_BITS = 13;
    localparam int STEP_BITS = 10;
    localparam int IDX_BITS  = 3;

    typedef logic [TEMP_BITS-1:0] t_temp;
    typedef logic [STEP_BITS-1:0] t_step;

    localparam logic [IDX_BITS-1:0] REG_TARGET       = 3'd0;
    localparam logic [IDX_BITS-1:0] REG_SWITCH_START = 3'd1;
    localparam logic [IDX_BITS-1:0] REG_COOLED       = 3'd2;
    localparam logic [IDX_BITS-1:0] REG_COOL_TRIM    = 3'd3;
    localparam logic [IDX_BITS-1:0] REG_FIRST_FAN    = 3'd4;
    localparam logic [IDX_BITS-1:0] REG_FAN_STEP     = 3'd5;
    localparam logic [IDX_BITS-1:0] REG_PURGE        = 3'd6;

    localparam t_temp RST_TARGET       = TEMP_BITS'(1072);
    localparam t_temp RST_SWITCH_START = TEMP_BITS'(631);
    localparam t_temp RST_COOLED       = TEMP_BITS'(360);
    localparam t_temp RST_COOL_TRIM    = TEMP_BITS'(1080);
    localparam t_temp RST_FIRST_FAN    = TEMP_BITS'(800);
    localparam t_step RST_FAN_STEP     = STEP_BITS'(120);
    localparam t_temp RST_PURGE        = TEMP_BITS'(880);

    typedef struct packed {
        t_temp target;
        t_temp switch_start;
        t_temp cooled;
        t_temp cool_trim;
        t_temp first_fan;
        t_step fan_step;
        t_temp purge;
    } t_cfg;

    typedef struct packed {
        logic  outtake;
        logic  intake;
        logic  barrel;
        logic  main;
        logic  smoke;
    } t_pins;

    typedef struct packed {
        logic  started;
        logic  cool_mode;
        logic  phase_smoke;
        logic  purged;
        logic  done;
        t_temp next_fan;
        t_pins pins;
        logic  link_ok;
    } t_state;

    typedef struct packed {
        t_pins pins;
        logic  short_pulse;
        logic  purge_pulse;
        logic  cooling;
        logic  finished;
        logic  link_check_ok;
    } t_result;

endpackage

FILE: rtl/rhs_step.sv
// Next-state and result logic for one temperature word.
// Depends on rhs_pkg.
module rhs_step (
    input  rhs_pkg::t_state  i_state,
    input  rhs_pkg::t_cfg    i_cfg,
    input  rhs_pkg::t_temp   i_temp,
    output rhs_pkg::t_state  o_state,
    output rhs_pkg::t_result o_result
);

    logic [rhs_pkg::TEMP_BITS:0] fan_sum;
    rhs_pkg::t_state             st;
    logic                        short_req;
    logic                        purge_req;

    assign fan_sum = {1'b0, i_state.next_fan}
                   + (rhs_pkg::TEMP_BITS+1)'(i_cfg.fan_step);

    always_comb begin
        st        = i_state;
        short_req = 1'b0;
        purge_req = 1'b0;

        if (!st.started) begin
            st.started     = 1'b1;
            st.pins.barrel = 1'b1;
            st.pins.main   = 1'b1;
        end

        if (!st.done) begin
            if (i_temp >= st.next_fan) begin
                short_req      = 1'b1;
                st.pins.intake = 1'b0;
                st.next_fan    = fan_sum[rhs_pkg::TEMP_BITS] ? '1
                                 : fan_sum[rhs_pkg::TEMP_BITS-1:0];
            end

            if (i_temp >= i_cfg.purge && !st.purged) begin
                purge_req       = 1'b1;
                st.pins.intake  = 1'b0;
                st.pins.outtake = 1'b0;
                st.purged       = 1'b1;
            end

            if (st.cool_mode && i_temp <= i_cfg.cool_trim && i_temp > i_cfg.cooled) begin
                st.pins.smoke = 1'b0;
            end else if (st.cool_mode && i_temp <= i_cfg.cooled) begin
                st.pins = '0;
                st.done = 1'b1;
            end else if (i_temp >= i_cfg.target && !st.cool_mode) begin
                st.link_ok      = 1'b0;
                st.pins.main    = 1'b0;
                st.pins.smoke   = 1'b1;
                st.pins.outtake = 1'b1;
                st.pins.intake  = 1'b1;
                st.cool_mode    = 1'b1;
            end else if (i_temp >= i_cfg.switch_start && i_temp < i_cfg.target
                         && !st.cool_mode) begin
                st.pins.smoke  = st.phase_smoke;
                st.pins.main   = !st.phase_smoke;
                st.phase_smoke = !st.phase_smoke;
            end
        end
    end

    assign o_state                = st;
    assign o_result.pins          = st.pins;
    assign o_result.short_pulse   = short_req;
    assign o_result.purge_pulse   = purge_req;
    assign o_result.cooling       = st.cool_mode;
    assign o_result.finished      = st.done;
    assign o_result.link_check_ok = st.link_ok;

endmodule

FILE: rtl/roast_heat_sequencer.sv
// Roast heat sequencer top level: handshakes, config registers, state, output stage.
// Depends on rhs_pkg and rhs_step.
// A result word is registered in the output register, or in the skid register while the output is stalled.
// Throughput: one word per cycle unless the skid register is full; the state update is a single registered pass.
// Under an output stall the skid register takes one more word, then ready drops.
// Reset (synchronous, active low) restores register defaults, sets the state to its reset values and clears valids.
module roast_heat_sequencer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [12:0] i_temperature,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_smoke_heater_on,
    output logic        o_main_heater_on,
    output logic        o_barrel_on,
    output logic        o_intake_fan_on,
    output logic        o_outtake_fan_on,
    output logic        o_short_pulse,
    output logic        o_purge_pulse,
    output logic        o_cooling,
    output logic        o_finished,
    output logic        o_link_check_ok,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    rhs_pkg::t_cfg    r_cfg;
    rhs_pkg::t_state  r_state;
    rhs_pkg::t_state  n_state;
    rhs_pkg::t_result n_result;
    rhs_pkg::t_result r_out;
    rhs_pkg::t_result r_skid;
    logic             r_out_v;
    logic             r_skid_v;
    logic             in_fire;
    logic             out_fire;
    logic             cfg_wr;
    logic [rhs_pkg::IDX_BITS-1:0] cfg_idx;

    assign pready   = 1'b1;
    assign cfg_idx  = paddr[4:2];
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign o_ready  = !r_skid_v;
    assign in_fire  = i_valid && o_ready;
    assign out_fire = r_out_v && i_ready;

    rhs_step u_step (
        .i_state  (r_state),
        .i_cfg    (r_cfg),
        .i_temp   (rhs_pkg::t_temp'(i_temperature)),
        .o_state  (n_state),
        .o_result (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.target       <= rhs_pkg::RST_TARGET;
            r_cfg.switch_start <= rhs_pkg::RST_SWITCH_START;
            r_cfg.cooled       <= rhs_pkg::RST_COOLED;
            r_cfg.cool_trim    <= rhs_pkg::RST_COOL_TRIM;
            r_cfg.first_fan    <= rhs_pkg::RST_FIRST_FAN;
            r_cfg.fan_step     <= rhs_pkg::RST_FAN_STEP;
            r_cfg.purge        <= rhs_pkg::RST_PURGE;
        end else if (cfg_wr) begin
            case (cfg_idx)
                rhs_pkg::REG_TARGET:       r_cfg.target       <= pwdata[rhs_pkg::TEMP_BITS-1:0];
                rhs_pkg::REG_SWITCH_START: r_cfg.switch_start <= pwdata[rhs_pkg::TEMP_BITS-1:0];
                rhs_pkg::REG_COOLED:       r_cfg.cooled       <= pwdata[rhs_pkg::TEMP_BITS-1:0];
                rhs_pkg::REG_COOL_TRIM:    r_cfg.cool_trim    <= pwdata[rhs_pkg::TEMP_BITS-1:0];
                rhs_pkg::REG_FIRST_FAN:    r_cfg.first_fan    <= pwdata[rhs_pkg::TEMP_BITS-1:0];
                rhs_pkg::REG_FAN_STEP:     r_cfg.fan_step     <= pwdata[rhs_pkg::STEP_BITS-1:0];
                rhs_pkg::REG_PURGE:        r_cfg.purge        <= pwdata[rhs_pkg::TEMP_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            rhs_pkg::REG_TARGET:       prdata = 32'(r_cfg.target);
            rhs_pkg::REG_SWITCH_START: prdata = 32'(r_cfg.switch_start);
            rhs_pkg::REG_COOLED:       prdata = 32'(r_cfg.cooled);
            rhs_pkg::REG_COOL_TRIM:    prdata = 32'(r_cfg.cool_trim);
            rhs_pkg::REG_FIRST_FAN:    prdata = 32'(r_cfg.first_fan);
            rhs_pkg::REG_FAN_STEP:     prdata = 32'(r_cfg.fan_step);
            rhs_pkg::REG_PURGE:        prdata = 32'(r_cfg.purge);
            default:                   prdata = '0;
        endcase
    end

    // first_fan write reloads the fan threshold straight away
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.started     <= 1'b0;
            r_state.cool_mode   <= 1'b0;
            r_state.phase_smoke <= 1'b1;
            r_state.purged      <= 1'b0;
            r_state.done        <= 1'b0;
            r_state.next_fan    <= rhs_pkg::RST_FIRST_FAN;
            r_state.pins        <= '0;
            r_state.link_ok     <= 1'b1;
        end else if (cfg_wr && cfg_idx == rhs_pkg::REG_FIRST_FAN) begin
            r_state.next_fan <= pwdata[rhs_pkg::TEMP_BITS-1:0];
        end else if (in_fire) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else begin
            if (out_fire || !r_out_v) begin
                r_out_v <= r_skid_v || in_fire;
            end
            if (in_fire && r_out_v && !out_fire) begin
                r_skid_v <= 1'b1;
            end else if (out_fire) begin
                r_skid_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_fire || !r_out_v) begin
            r_out <= r_skid_v ? r_skid : n_result;
        end
        if (in_fire && r_out_v && !out_fire) begin
            r_skid <= n_result;
        end
    end

    assign o_valid           = r_out_v;
    assign o_smoke_heater_on = r_out.pins.smoke;
    assign o_main_heater_on  = r_out.pins.main;
    assign o_barrel_on       = r_out.pins.barrel;
    assign o_intake_fan_on   = r_out.pins.intake;
    assign o_outtake_fan_on  = r_out.pins.outtake;
    assign o_short_pulse     = r_out.short_pulse;
    assign o_purge_pulse     = r_out.purge_pulse;
    assign o_cooling         = r_out.cooling;
    assign o_finished        = r_out.finished;
    assign o_link_check_ok   = r_out.link_check_ok;

`ifndef SYNTHESIS
    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_out_v)
        else $error("skid word held with output register empty");

    a_done_sticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.done |=> r_state.done)
        else $error("done state cleared without reset");

    a_finished_all_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_finished) |-> (r_out.pins == '0))
        else $error("finished word shows a level still on");

    a_cool_no_link: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.cool_mode |-> !r_state.link_ok)
        else $error("link check allowed in cool mode");
`endif

endmodule
